### src/assert_macros.svh
// Assertion macros used by the sequencer RTL of the matching swap upgrade block.
// Each macro checks one clocked implication, disabled while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mswu_pkg.sv
// Shared types and constants of the matching swap upgrade block.
// Used by the sequencer, the result buffer and the top level; depends on nothing.
`timescale 1ns / 1ps

package mswu_pkg;

    // Widths of the fixed payload fields.
    localparam int IDX_W  = 6;
    localparam int COST_W = 32;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [COST_W-1:0] t_cost_in;

    // Operation carried by an input transaction.
    typedef enum logic [1:0] {
        KIND_LOAD_COST = 2'd0,
        KIND_LOAD_FWD  = 2'd1,
        KIND_PROPOSE   = 2'd2,
        KIND_READ      = 2'd3
    } t_kind;

    // Input transaction payload.
    typedef struct packed {
        t_kind    kind;
        t_idx     source_index;
        t_idx     target_index;
        t_cost_in cost_value;
    } t_in;

    // Result transaction payload.
    typedef struct packed {
        t_idx mapped_target;
        logic swapped;
        logic displaced_owner_valid;
    } t_out;

    // Write strobes of the three state memories.
    typedef struct packed {
        logic fwd;
        logic inv;
        logic cost;
    } t_mem_we;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_LOAD_CHK,
        ST_LOAD_OWN,
        ST_COST_AB,
        ST_MOVE_OWN,
        ST_COST_APBP,
        ST_COST_APB,
        ST_SWAP_CMP,
        ST_SWAP_WR,
        ST_DONE
    } t_state;

endpackage

### src/mswu_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; used for every state memory of the block.
`timescale 1ns / 1ps

module mswu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mswu_obuf.sv
// Result register that holds one finished transaction until the consumer takes it.
// Depends on mswu_pkg for the result payload type.
`timescale 1ns / 1ps

module mswu_obuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mswu_pkg::t_out  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output mswu_pkg::t_out  o_data
);

    logic           r_valid;
    logic           n_valid;
    mswu_pkg::t_out r_data;
    mswu_pkg::t_out n_data;

    // The slot takes a new result when empty or when its content leaves this cycle.
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
            n_data  = i_data;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/mswu_seq.sv
// Sequencer of the matching swap upgrade block: reads, decides and writes back
// the forward map, inverse map and cost memories. Depends on mswu_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mswu_seq #(
    parameter int SOURCES   = 64,
    parameter int TARGETS   = 64,
    parameter int COST_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  mswu_pkg::t_in                        i_in_data,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output mswu_pkg::t_out                       o_res,
    output mswu_pkg::t_mem_we                    o_we,
    output logic [$clog2(SOURCES)-1:0]           o_fwd_waddr,
    output logic [$clog2(TARGETS)-1:0]           o_fwd_wdata,
    output logic [$clog2(SOURCES)-1:0]           o_fwd_raddr,
    input  logic [$clog2(TARGETS)-1:0]           i_fwd_rdata,
    output logic [$clog2(TARGETS)-1:0]           o_inv_waddr,
    output logic [$clog2(SOURCES):0]             o_inv_wdata,
    output logic [$clog2(TARGETS)-1:0]           o_inv_raddr,
    input  logic [$clog2(SOURCES):0]             i_inv_rdata,
    output logic [$clog2(SOURCES)+$clog2(TARGETS)-1:0] o_cost_waddr,
    output logic [COST_BITS-1:0]                 o_cost_wdata,
    output logic [$clog2(SOURCES)+$clog2(TARGETS)-1:0] o_cost_raddr,
    input  logic [COST_BITS-1:0]                 i_cost_rdata
);

    localparam int SRC_W = $clog2(SOURCES);
    localparam int TGT_W = $clog2(TARGETS);
    localparam int INV_W = SRC_W + 1;

    mswu_pkg::t_state  r_state;
    mswu_pkg::t_state  n_state;
    logic [TGT_W-1:0]  r_clr;
    logic [TGT_W-1:0]  n_clr;
    mswu_pkg::t_in     r_item;
    mswu_pkg::t_in     n_item;
    logic [TGT_W-1:0]  r_b;
    logic [TGT_W-1:0]  n_b;
    logic [SRC_W-1:0]  r_ap;
    logic [SRC_W-1:0]  n_ap;
    logic              r_owned;
    logic              n_owned;
    logic [COST_BITS-1:0] r_c_abp;
    logic [COST_BITS-1:0] n_c_abp;
    logic [COST_BITS-1:0] r_c_ab;
    logic [COST_BITS-1:0] n_c_ab;
    logic [COST_BITS:0]   r_now;
    logic [COST_BITS:0]   n_now;
    logic [COST_BITS:0]   r_alt;
    logic [COST_BITS:0]   n_alt;
    mswu_pkg::t_out    r_res;
    mswu_pkg::t_out    n_res;

    logic [SRC_W-1:0]  a_in;
    logic [TGT_W-1:0]  bp_in;
    logic [SRC_W-1:0]  w_a;
    logic [TGT_W-1:0]  w_bp;
    logic              w_bad;
    logic              w_b_ok;
    logic              w_bp_self;
    logic              w_noop;
    logic              w_old_mine;

    // Indexes of the incoming and of the held transaction, sized to the memories.
    assign a_in  = SRC_W'(i_in_data.source_index);
    assign bp_in = TGT_W'(i_in_data.target_index);
    assign w_a   = SRC_W'(r_item.source_index);
    assign w_bp  = TGT_W'(r_item.target_index);

    // Range checks and proposal screening on the data read for the held transaction.
    assign w_bad = (32'(r_item.source_index) >= 32'(SOURCES)) ||
                   ((r_item.kind != mswu_pkg::KIND_READ) &&
                    (32'(r_item.target_index) >= 32'(TARGETS)));
    assign w_b_ok     = 32'(i_fwd_rdata) < 32'(TARGETS);
    assign w_bp_self  = i_inv_rdata[INV_W-1] && (i_inv_rdata[SRC_W-1:0] == w_a);
    assign w_noop     = !w_b_ok || w_bp_self || (i_fwd_rdata == w_bp);
    assign w_old_mine = i_inv_rdata[INV_W-1] && (i_inv_rdata[SRC_W-1:0] == w_a) &&
                        (32'(r_b) < 32'(TARGETS));

    // Next state, memory addresses and write strobes.
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_item   = r_item;
        n_b      = r_b;
        n_ap     = r_ap;
        n_owned  = r_owned;
        n_c_abp  = r_c_abp;
        n_c_ab   = r_c_ab;
        n_now    = r_now;
        n_alt    = r_alt;
        n_res    = r_res;

        o_we         = '0;
        o_fwd_waddr  = w_a;
        o_fwd_wdata  = w_bp;
        o_fwd_raddr  = a_in;
        o_inv_waddr  = w_bp;
        o_inv_wdata  = {1'b1, w_a};
        o_inv_raddr  = bp_in;
        o_cost_waddr = {w_a, w_bp};
        o_cost_wdata = COST_BITS'(r_item.cost_value);
        o_cost_raddr = {a_in, bp_in};

        case (r_state)
            mswu_pkg::ST_CLEAR: begin
                // Mark every inverse entry free, one per cycle.
                o_we.inv    = 1'b1;
                o_inv_waddr = r_clr;
                o_inv_wdata = '0;
                n_clr       = r_clr + TGT_W'(1);
                if (&r_clr) begin
                    n_state = mswu_pkg::ST_IDLE;
                end
            end
            mswu_pkg::ST_IDLE: begin
                // Reads of forward[a], inverse[bp] and cost[a][bp] start on acceptance.
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = mswu_pkg::ST_LOOK;
                end
            end
            mswu_pkg::ST_LOOK: begin
                n_b          = i_fwd_rdata;
                n_ap         = i_inv_rdata[SRC_W-1:0];
                n_owned      = i_inv_rdata[INV_W-1];
                n_c_abp      = i_cost_rdata;
                n_res        = '0;
                n_state      = mswu_pkg::ST_DONE;
                o_inv_raddr  = i_fwd_rdata;
                o_cost_raddr = {w_a, i_fwd_rdata};
                if (!w_bad) begin
                    case (r_item.kind)
                        mswu_pkg::KIND_LOAD_COST: begin
                            o_we.cost = 1'b1;
                        end
                        mswu_pkg::KIND_LOAD_FWD: begin
                            n_state = mswu_pkg::ST_LOAD_CHK;
                        end
                        mswu_pkg::KIND_READ: begin
                            n_res.mapped_target = mswu_pkg::t_idx'(i_fwd_rdata);
                        end
                        mswu_pkg::KIND_PROPOSE: begin
                            n_res.mapped_target = mswu_pkg::t_idx'(i_fwd_rdata);
                            if (!w_noop) begin
                                n_state = mswu_pkg::ST_COST_AB;
                            end
                        end
                        default: begin
                            n_state = mswu_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            mswu_pkg::ST_LOAD_CHK: begin
                // Free the old target if this source still owns it, then remap.
                o_we.fwd = 1'b1;
                if (w_old_mine) begin
                    o_we.inv    = 1'b1;
                    o_inv_waddr = r_b;
                    o_inv_wdata = '0;
                end
                n_state = mswu_pkg::ST_LOAD_OWN;
            end
            mswu_pkg::ST_LOAD_OWN: begin
                o_we.inv            = 1'b1;
                n_res.mapped_target = r_item.target_index;
                n_state             = mswu_pkg::ST_DONE;
            end
            mswu_pkg::ST_COST_AB: begin
                n_c_ab       = i_cost_rdata;
                o_cost_raddr = {r_ap, w_bp};
                if (r_owned) begin
                    n_state = mswu_pkg::ST_COST_APBP;
                end else if (r_c_abp < i_cost_rdata) begin
                    // Move to the free target and release the old one.
                    o_we.fwd            = 1'b1;
                    o_we.inv            = 1'b1;
                    o_inv_waddr         = r_b;
                    o_inv_wdata         = '0;
                    n_res.mapped_target = r_item.target_index;
                    n_res.swapped       = 1'b1;
                    n_state             = mswu_pkg::ST_MOVE_OWN;
                end else begin
                    n_state = mswu_pkg::ST_DONE;
                end
            end
            mswu_pkg::ST_MOVE_OWN: begin
                o_we.inv = 1'b1;
                n_state  = mswu_pkg::ST_DONE;
            end
            mswu_pkg::ST_COST_APBP: begin
                n_now        = {1'b0, r_c_ab} + {1'b0, i_cost_rdata};
                o_cost_raddr = {r_ap, r_b};
                n_state      = mswu_pkg::ST_COST_APB;
            end
            mswu_pkg::ST_COST_APB: begin
                n_alt   = {1'b0, i_cost_rdata} + {1'b0, r_c_abp};
                n_state = mswu_pkg::ST_SWAP_CMP;
            end
            mswu_pkg::ST_SWAP_CMP: begin
                // Exchange targets with the owner only on a strict improvement.
                if (r_alt < r_now) begin
                    o_we.fwd                    = 1'b1;
                    o_we.inv                    = 1'b1;
                    n_res.mapped_target         = r_item.target_index;
                    n_res.swapped               = 1'b1;
                    n_res.displaced_owner_valid = 1'b1;
                    n_state                     = mswu_pkg::ST_SWAP_WR;
                end else begin
                    n_state = mswu_pkg::ST_DONE;
                end
            end
            mswu_pkg::ST_SWAP_WR: begin
                o_we.fwd    = 1'b1;
                o_fwd_waddr = r_ap;
                o_fwd_wdata = r_b;
                o_we.inv    = 1'b1;
                o_inv_waddr = r_b;
                o_inv_wdata = {1'b1, r_ap};
                n_state     = mswu_pkg::ST_DONE;
            end
            mswu_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = mswu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mswu_pkg::ST_IDLE;
            end
        endcase
    end

    // State register and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mswu_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_item  <= n_item;
        r_b     <= n_b;
        r_ap    <= n_ap;
        r_owned <= n_owned;
        r_c_abp <= n_c_abp;
        r_c_ab  <= n_c_ab;
        r_now   <= n_now;
        r_alt   <= n_alt;
        r_res   <= n_res;
    end

    assign o_in_ready  = (r_state == mswu_pkg::ST_IDLE);
    assign o_res_valid = (r_state == mswu_pkg::ST_DONE);
    assign o_res       = r_res;

    // An accepted transaction always starts with the lookup of its entries.
    `ASSERT_NEXT(a_accept_look, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == mswu_pkg::ST_LOOK, "accepted transaction did not start a lookup")
    // A changed matching always leaves the source on the proposed target.
    `ASSERT_IMPLY(a_swap_target, i_clk, i_rst_n, o_res_valid && o_res.swapped, o_res.mapped_target == r_item.target_index, "swap result does not map to the proposed target")
    // A displaced owner is reported only for a proposal that changed the matching.
    `ASSERT_IMPLY(a_displace_swap, i_clk, i_rst_n, o_res_valid && o_res.displaced_owner_valid, o_res.swapped && (r_item.kind == mswu_pkg::KIND_PROPOSE), "displaced owner without a swap")
    // No write back is pending while a new transaction can be read.
    `ASSERT_IMPLY(a_ready_quiet, i_clk, i_rst_n, o_in_ready, !o_we.fwd && !o_we.inv && !o_we.cost && !o_res_valid, "write or result overlaps a new lookup")

endmodule

### src/matching_swap_upgrade.sv
// Matching swap upgrade block: keeps a one-to-one matching of sources to targets with
// a cost table and takes proposals that strictly lower the summed cost. Each input
// transaction gives exactly one result. Items are worked one at a time. The single
// read port of the cost memory serves the four dependent cost reads of a proposal
// one after another, and each map memory has a single write port. The result register
// lets the next item enter while a result still waits. After reset all
// 2**ceil(log2(TARGETS)) entries of the inverse map are swept free, one entry per
// cycle, during which no item is accepted. Depends on mswu_pkg, mswu_seq, mswu_ram
// and mswu_obuf.
`timescale 1ns / 1ps

module matching_swap_upgrade #(
    parameter int SOURCES   = 64,
    parameter int TARGETS   = 64,
    parameter int COST_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mswu_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mswu_pkg::t_out o_out_data
);

    localparam int SRC_W = $clog2(SOURCES);
    localparam int TGT_W = $clog2(TARGETS);
    localparam int INV_W = SRC_W + 1;
    localparam int CA_W  = SRC_W + TGT_W;

    mswu_pkg::t_mem_we  mem_we;
    logic [SRC_W-1:0]   fwd_waddr;
    logic [TGT_W-1:0]   fwd_wdata;
    logic [SRC_W-1:0]   fwd_raddr;
    logic [TGT_W-1:0]   fwd_rdata;
    logic [TGT_W-1:0]   inv_waddr;
    logic [INV_W-1:0]   inv_wdata;
    logic [TGT_W-1:0]   inv_raddr;
    logic [INV_W-1:0]   inv_rdata;
    logic [CA_W-1:0]    cost_waddr;
    logic [COST_BITS-1:0] cost_wdata;
    logic [CA_W-1:0]    cost_raddr;
    logic [COST_BITS-1:0] cost_rdata;
    logic               res_valid;
    logic               res_ready;
    mswu_pkg::t_out     res_data;

    // Sequencer.
    mswu_seq #(
        .SOURCES   (SOURCES),
        .TARGETS   (TARGETS),
        .COST_BITS (COST_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res_data),
        .o_we         (mem_we),
        .o_fwd_waddr  (fwd_waddr),
        .o_fwd_wdata  (fwd_wdata),
        .o_fwd_raddr  (fwd_raddr),
        .i_fwd_rdata  (fwd_rdata),
        .o_inv_waddr  (inv_waddr),
        .o_inv_wdata  (inv_wdata),
        .o_inv_raddr  (inv_raddr),
        .i_inv_rdata  (inv_rdata),
        .o_cost_waddr (cost_waddr),
        .o_cost_wdata (cost_wdata),
        .o_cost_raddr (cost_raddr),
        .i_cost_rdata (cost_rdata)
    );

    // Forward map: source to target.
    mswu_ram #(
        .WIDTH (TGT_W),
        .DEPTH (1 << SRC_W)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we.fwd),
        .i_waddr (fwd_waddr),
        .i_wdata (fwd_wdata),
        .i_raddr (fwd_raddr),
        .o_rdata (fwd_rdata)
    );

    // Inverse map: target to owner flag and owning source.
    mswu_ram #(
        .WIDTH (INV_W),
        .DEPTH (1 << TGT_W)
    ) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we.inv),
        .i_waddr (inv_waddr),
        .i_wdata (inv_wdata),
        .i_raddr (inv_raddr),
        .o_rdata (inv_rdata)
    );

    // Cost table, addressed by source and target.
    mswu_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (1 << CA_W)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we.cost),
        .i_waddr (cost_waddr),
        .i_wdata (cost_wdata),
        .i_raddr (cost_raddr),
        .o_rdata (cost_rdata)
    );

    // Result register toward the consumer.
    mswu_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_data  (res_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

### dv/matching_swap_upgrade_tb.sv
// Self-checking testbench for matching_swap_upgrade: directed and random transactions
// against a behavioral mirror of the matching, checked in order on the result channel.
// Depends on mswu_pkg and the RTL of the block.
`timescale 1ns / 1ps

localparam int N_SRC = 64;
localparam int N_TGT = 64;

// Mirror of the matching state. It predicts the result of every accepted transaction
// and compares the results that come back in order.
class matching_mirror;
    bit [5:0]  fwd_tgt   [N_SRC];
    bit        fwd_set   [N_SRC];
    bit [5:0]  owner_of  [N_TGT];
    bit        owner_set [N_TGT];
    bit [31:0] cost_of   [N_SRC*N_TGT];
    bit        cost_set  [N_SRC*N_TGT];
    mswu_pkg::t_out awaited [$];
    int        failures;

    function int cost_slot(int s, int t);
        return s * N_TGT + t;
    endfunction

    function bit is_loaded(mswu_pkg::t_idx s);
        return fwd_set[s];
    endfunction

    function mswu_pkg::t_idx target_of(mswu_pkg::t_idx s);
        return fwd_tgt[s];
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    // First cost entry that a proposal could read but that was never written, or -1.
    function int next_missing_cost(mswu_pkg::t_idx a, mswu_pkg::t_idx bp);
        int             slots [4];
        int             n;
        mswu_pkg::t_idx b;
        mswu_pkg::t_idx ap;
        b = fwd_tgt[a];
        slots[0] = cost_slot(a, b);
        slots[1] = cost_slot(a, bp);
        n = 2;
        if (owner_set[bp]) begin
            ap = owner_of[bp];
            slots[2] = cost_slot(ap, bp);
            slots[3] = cost_slot(ap, b);
            n = 4;
        end
        for (int i = 0; i < n; i++) begin
            if (!cost_set[slots[i]]) begin
                return slots[i];
            end
        end
        return -1;
    endfunction

    // Update the mirror with one accepted transaction and queue its result.
    function void apply_item(mswu_pkg::t_in item);
        mswu_pkg::t_out res;
        mswu_pkg::t_idx a;
        mswu_pkg::t_idx bp;
        mswu_pkg::t_idx b;
        mswu_pkg::t_idx ap;
        bit [32:0]      now_sum;
        bit [32:0]      alt_sum;
        a = item.source_index;
        bp = item.target_index;
        res = '0;
        case (item.kind)
            mswu_pkg::KIND_LOAD_COST: begin
                cost_of[cost_slot(a, bp)] = item.cost_value;
                cost_set[cost_slot(a, bp)] = 1'b1;
            end
            mswu_pkg::KIND_LOAD_FWD: begin
                // A reload frees the old target only if this source still owns it.
                if (fwd_set[a]) begin
                    b = fwd_tgt[a];
                    if (owner_set[b] && owner_of[b] == a) begin
                        owner_set[b] = 1'b0;
                    end
                end
                fwd_tgt[a] = bp;
                fwd_set[a] = 1'b1;
                owner_of[bp] = a;
                owner_set[bp] = 1'b1;
                res.mapped_target = bp;
            end
            mswu_pkg::KIND_READ: begin
                if (fwd_set[a]) begin
                    res.mapped_target = fwd_tgt[a];
                end
            end
            mswu_pkg::KIND_PROPOSE: begin
                if (fwd_set[a]) begin
                    b = fwd_tgt[a];
                    res.mapped_target = b;
                    if (!(owner_set[bp] && owner_of[bp] == a) && b != bp) begin
                        if (owner_set[bp]) begin
                            // Owned target: exchange targets if the pair sum drops.
                            ap = owner_of[bp];
                            now_sum = {1'b0, cost_of[cost_slot(a, b)]}
                                    + {1'b0, cost_of[cost_slot(ap, bp)]};
                            alt_sum = {1'b0, cost_of[cost_slot(ap, b)]}
                                    + {1'b0, cost_of[cost_slot(a, bp)]};
                            if (alt_sum < now_sum) begin
                                fwd_tgt[a] = bp;
                                fwd_tgt[ap] = b;
                                fwd_set[ap] = 1'b1;
                                owner_of[bp] = a;
                                owner_of[b] = ap;
                                owner_set[b] = 1'b1;
                                res.mapped_target = bp;
                                res.swapped = 1'b1;
                                res.displaced_owner_valid = 1'b1;
                            end
                        end else if (cost_of[cost_slot(a, bp)] < cost_of[cost_slot(a, b)]) begin
                            // Free target: move there and free the old one.
                            fwd_tgt[a] = bp;
                            owner_set[b] = 1'b0;
                            owner_of[bp] = a;
                            owner_set[bp] = 1'b1;
                            res.mapped_target = bp;
                            res.swapped = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        awaited = {awaited, res};
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(mswu_pkg::t_out got);
        mswu_pkg::t_out want;
        if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("unexpected result: mapped_target %0d swapped %0d displaced %0d",
                         got.mapped_target, got.swapped, got.displaced_owner_valid);
            end
            return;
        end
        want = awaited.pop_front();
        if (got.mapped_target !== want.mapped_target || got.swapped !== want.swapped
                || got.displaced_owner_valid !== want.displaced_owner_valid) begin
            failures++;
            if (failures <= 10) begin
                $display({"result mismatch: mapped_target exp %0d got %0d, ",
                          "swapped exp %0d got %0d, ",
                          "displaced_owner_valid exp %0d got %0d"},
                         want.mapped_target, got.mapped_target, want.swapped, got.swapped,
                         want.displaced_owner_valid, got.displaced_owner_valid);
            end
        end
    endfunction
endclass

module matching_swap_upgrade_tb;

    localparam mswu_pkg::t_cost_in COST_MAX = '1;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    mswu_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    mswu_pkg::t_out o_out_data;

    matching_mirror mirror;
    int             items_sent;
    bit             steady;
    int             r;
    int             tries;
    mswu_pkg::t_idx s;
    mswu_pkg::t_idx t;

    matching_swap_upgrade dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 12 ns clock.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Indices favor a small hot set so that sources collide on targets.
    function automatic mswu_pkg::t_idx pick_index();
        if ($urandom_range(0, 9) < 7) begin
            return mswu_pkg::t_idx'($urandom_range(0, 7) * 9);
        end
        return mswu_pkg::t_idx'($urandom_range(0, N_SRC - 1));
    endfunction

    // Costs mix small values (ties), full range and values at the top of the range.
    function automatic mswu_pkg::t_cost_in pick_cost();
        int p;
        p = $urandom_range(0, 99);
        if (p < 35) return mswu_pkg::t_cost_in'($urandom_range(0, 7));
        if (p < 65) return mswu_pkg::t_cost_in'($urandom());
        if (p < 75) return '0;
        if (p < 85) return COST_MAX;
        return COST_MAX - mswu_pkg::t_cost_in'($urandom_range(0, 7));
    endfunction

    function automatic mswu_pkg::t_in build(mswu_pkg::t_kind k, mswu_pkg::t_idx src,
                                            mswu_pkg::t_idx tgt, mswu_pkg::t_cost_in c);
        mswu_pkg::t_in item;
        item.kind = k;
        item.source_index = src;
        item.target_index = tgt;
        item.cost_value = c;
        return item;
    endfunction

    // Drive one input transaction from a falling edge and wait for its acceptance.
    task automatic send_item(input mswu_pkg::t_in item);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        mirror.apply_item(item);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_cost(input mswu_pkg::t_idx src, input mswu_pkg::t_idx tgt,
                             input mswu_pkg::t_cost_in c);
        send_item(build(mswu_pkg::KIND_LOAD_COST, src, tgt, c));
    endtask

    task automatic load_fwd(input mswu_pkg::t_idx src, input mswu_pkg::t_idx tgt);
        send_item(build(mswu_pkg::KIND_LOAD_FWD, src, tgt,
                        mswu_pkg::t_cost_in'($urandom())));
    endtask

    task automatic read_src(input mswu_pkg::t_idx src);
        send_item(build(mswu_pkg::KIND_READ, src, mswu_pkg::t_idx'($urandom()),
                        mswu_pkg::t_cost_in'($urandom())));
    endtask

    // A proposal is preceded by writes of any cost entry it may read.
    task automatic propose(input mswu_pkg::t_idx src, input mswu_pkg::t_idx tgt);
        int slot;
        slot = mirror.next_missing_cost(src, tgt);
        while (slot >= 0) begin
            load_cost(mswu_pkg::t_idx'(slot / N_TGT), mswu_pkg::t_idx'(slot % N_TGT),
                      pick_cost());
            slot = mirror.next_missing_cost(src, tgt);
        end
        send_item(build(mswu_pkg::KIND_PROPOSE, src, tgt,
                        mswu_pkg::t_cost_in'($urandom())));
    endtask

    // Result side: ready with random stalls, sometimes held high for long stretches.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(50, 150)) @(negedge i_clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    // Results are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            mirror.check_result(o_out_data);
        end
    end

    initial begin
        mirror = new();
        items_sent = 0;
        steady = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: corner costs, overflowing sums, each kind of proposal outcome.
        load_cost(6'd0, 6'd0, '0);
        load_cost(6'd63, 6'd63, COST_MAX);
        load_cost(6'd0, 6'd63, COST_MAX);
        load_cost(6'd63, 6'd0, COST_MAX);
        load_fwd(6'd0, 6'd0);
        load_fwd(6'd63, 6'd63);
        read_src(6'd0);
        read_src(6'd63);
        // The exchanged sum overflows 32 bits and must not win.
        propose(6'd0, 6'd63);
        // Proposing the current target changes nothing.
        propose(6'd0, 6'd0);
        load_cost(6'd0, 6'd63, '0);
        load_cost(6'd63, 6'd0, '0);
        propose(6'd0, 6'd63);
        read_src(6'd63);
        // Move to a free target, then a rejected move back, then an equal-cost tie.
        load_fwd(6'd21, 6'd21);
        load_cost(6'd21, 6'd21, 32'd100);
        load_cost(6'd21, 6'd42, 32'd99);
        propose(6'd21, 6'd42);
        propose(6'd21, 6'd21);
        load_cost(6'd21, 6'd21, 32'd99);
        propose(6'd21, 6'd21);
        // Another source takes an owned target; the old owner keeps its entry.
        load_fwd(6'd5, 6'd42);
        read_src(6'd21);
        // Reload of a source that still owns its target frees that target.
        load_fwd(6'd5, 6'd10);
        propose(6'd21, 6'd63);

        // Random part.
        while (items_sent < 525) begin
            steady = (items_sent >= 250 && items_sent < 310);
            r = $urandom_range(0, 99);
            s = pick_index();
            if (r < 15) begin
                load_cost(s, pick_index(), pick_cost());
            end else if (r < 30) begin
                load_fwd(s, pick_index());
            end else begin
                // Proposals and reads only for sources that were loaded.
                tries = 0;
                while (!mirror.is_loaded(s) && tries < 8) begin
                    s = pick_index();
                    tries++;
                end
                if (!mirror.is_loaded(s)) begin
                    load_fwd(s, pick_index());
                end else if (r < 82) begin
                    t = ($urandom_range(0, 6) == 0) ? mirror.target_of(s) : pick_index();
                    propose(s, t);
                end else begin
                    read_src(s);
                end
            end
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        // Drain the outstanding results, then watch for stray ones.
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mirror.failures == 0 && mirror.pending() == 0) begin
            $display("matching_swap_upgrade_tb: PASS");
        end else begin
            $display("matching_swap_upgrade_tb: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10_000_000;
        $display("matching_swap_upgrade_tb: FAIL");
        $finish;
    end

endmodule
